@@ sv/assert_macros.svh @@
// Assertion macros used by multichannel_semblance.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ sv/msemb_pkg.sv @@
// ----------------------------------------------------------------------------
// msemb_pkg
// Types and constants shared by the semblance controller and datapath.
// ----------------------------------------------------------------------------
package msemb_pkg;

    localparam int MAX_CHANNELS_DEF   = 64;
    localparam int MAX_HALF_WIDTH_DEF = 31;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int COH_W   = 17;
    localparam int TIME_W  = 20;
    localparam int NREC_W  = 7;
    localparam int HALF_W  = 5;
    localparam int ACC_W   = 64;
    localparam int QBITS   = 17;

    localparam logic [1:0] CFG_NUM_RECORDS = 2'd0;
    localparam logic [1:0] CFG_NUM_SAMPLES = 2'd1;
    localparam logic [1:0] CFG_HALF_WINDOW = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic acc_clear;   // clear window sums
        logic acc_step;    // add one ring entry at the walk position
        logic mul_d;       // form divisor num_records * SX
        logic div_init;    // start long division
        logic div_step;    // one quotient bit
        logic col_write;   // commit the column to the ring
    } t_cmd;

    // Datapath status back to the controller.
    typedef struct packed {
        logic col_done;    // current sample completes a time index
    } t_stat;

endpackage

@@ sv/msemb_datapath.sv @@
// ----------------------------------------------------------------------------
// msemb_datapath
// Column accumulation, result rings, weighted window sums and the
// bit-serial divider that forms the Q1.16 semblance.
// ----------------------------------------------------------------------------
module msemb_datapath #(
    parameter int MAX_CHANNELS   = 64,
    parameter int MAX_HALF_WIDTH = 31,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [msemb_pkg::NREC_W-1:0] i_nrec,
    input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] i_slot,
    input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] i_rd_slot,
    input  logic [6:0]                   i_weight,
    input  msemb_pkg::t_cmd              i_cmd,
    input  logic [msemb_pkg::NREC_W-1:0] i_cnt_next,
    output msemb_pkg::t_stat             o_stat,
    output logic [msemb_pkg::COH_W-1:0]  o_coh
);
    import msemb_pkg::*;

    localparam int DEPTH  = 2 * MAX_HALF_WIDTH + 1;
    localparam int CS_W   = SAMPLE_BITS + $clog2(MAX_CHANNELS) + 1;

    logic [ACC_W-1:0] r_ss_mem [DEPTH];
    logic [ACC_W-1:0] r_sx_mem [DEPTH];
    logic signed [CS_W-1:0] r_csum;
    logic [ACC_W-1:0] r_cen;
    logic [ACC_W-1:0] r_ss_rd, r_sx_rd;
    logic [ACC_W-1:0] r_ss, r_sx, r_d, r_rem;
    logic [QBITS-1:0] r_q;
    logic             r_zero, r_sat;
    logic [6:0]       r_wgt;
    logic             r_rd_ok;

    logic signed [CS_W-1:0] n_csum;
    logic [ACC_W-1:0]       n_cen;
    logic signed [2*SAMPLE_BITS-1:0] w_sample_sq;
    logic [CS_W-1:0]        w_mag;
    logic [2*CS_W-1:0]      w_sq_full;
    logic [ACC_W-1:0]       w_sq;
    logic [ACC_W-1:0]       w_rem2;
    logic [QBITS:0]         w_rnd;

    always_comb begin
        w_sample_sq = i_sample * i_sample;
        n_csum    = r_csum + CS_W'(i_sample);
        n_cen     = r_cen + ACC_W'($unsigned(w_sample_sq));
        w_mag     = n_csum[CS_W-1] ? CS_W'(-n_csum) : CS_W'(n_csum);
        w_sq_full = w_mag * w_mag;
        w_sq      = ACC_W'(w_sq_full);
        w_rem2    = {r_rem[ACC_W-2:0], 1'b0};
        w_rnd     = ({1'b0, r_q} + (QBITS+1)'(1)) >> 1;
    end

    assign o_stat.col_done = (i_cnt_next >= i_nrec - NREC_W'(1)) || (i_nrec <= NREC_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum  <= '0;
            r_cen   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= i_cmd.acc_step;
            if (i_take) begin
                if (i_cmd.col_write) begin
                    r_csum <= '0;
                    r_cen  <= '0;
                end else begin
                    r_csum <= n_csum;
                    r_cen  <= n_cen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_cmd.col_write) begin
            r_ss_mem[i_slot] <= w_sq;
            r_sx_mem[i_slot] <= n_cen;
        end
        r_ss_rd <= r_ss_mem[i_rd_slot];
        r_sx_rd <= r_sx_mem[i_rd_slot];
        r_wgt   <= i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_ss <= '0;
            r_sx <= '0;
        end else if (r_rd_ok) begin
            r_ss <= r_ss + r_ss_rd * ACC_W'(r_wgt);
            r_sx <= r_sx + r_sx_rd * ACC_W'(r_wgt);
        end
        if (i_cmd.mul_d) begin
            r_d <= r_sx * ACC_W'(i_nrec);
        end
        if (i_cmd.div_init) begin
            r_zero <= (r_sx == '0);
            r_sat  <= (r_ss >= r_d);
            r_rem  <= r_ss;
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            if (w_rem2 >= r_d) begin
                r_rem <= w_rem2 - r_d;
                r_q   <= {r_q[QBITS-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2;
                r_q   <= {r_q[QBITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_zero)      o_coh = '0;
        else if (r_sat)  o_coh = COH_W'(65536);
        else if (w_rnd > (QBITS+1)'(65536)) o_coh = COH_W'(65536);
        else             o_coh = COH_W'(w_rnd);
    end
endmodule

@@ sv/msemb_ctrl.sv @@
// ----------------------------------------------------------------------------
// msemb_ctrl
// Sequencer: counts channels and time, walks each window over the rings,
// runs the divider and hands results to the output register.
// ----------------------------------------------------------------------------
module msemb_ctrl #(
    parameter int MAX_HALF_WIDTH = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output logic                           o_take,
    input  logic [msemb_pkg::NREC_W-1:0]   i_nrec,
    input  logic [msemb_pkg::TIME_W-1:0]   i_nsamp,
    input  logic [msemb_pkg::HALF_W-1:0]   i_half,
    input  msemb_pkg::t_stat               i_stat,
    output msemb_pkg::t_cmd                o_cmd,
    output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] o_slot,
    output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] o_rd_slot,
    output logic [6:0]                     o_weight,
    output logic [msemb_pkg::NREC_W-1:0]   o_cnt_next,
    input  logic [msemb_pkg::COH_W-1:0]    i_coh,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [msemb_pkg::COH_W-1:0]    o_coh,
    output logic [msemb_pkg::TIME_W-1:0]   o_time,
    output logic                           o_end
);
    import msemb_pkg::*;

    localparam int DEPTH  = 2 * MAX_HALF_WIDTH + 1;
    localparam int SLOT_W = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_CLR  = 8'b00000010,
        S_WALK = 8'b00000100,
        S_LAND = 8'b00001000,
        S_MUL  = 8'b00010000,
        S_DINI = 8'b00100000,
        S_DIV  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [NREC_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_time, r_t, r_c, r_last, r_i, r_hi;
    logic [HALF_W:0]   r_h;
    logic [4:0]        r_bit;
    logic [SLOT_W-1:0] r_tslot, r_cslot, r_islot;

    logic [HALF_W:0]   w_h;
    logic [TIME_W-1:0] w_ns;
    logic              w_last;
    logic [TIME_W:0]   w_t1;
    logic [TIME_W-1:0] w_dist;
    logic [TIME_W:0]   w_hi;
    logic [SLOT_W-1:0] w_tslot_inc, w_cslot_inc, w_islot_inc;
    logic [SLOT_W-1:0] w_tsub, w_csub;

    always_comb begin
        w_h  = (HALF_W+1)'(i_half) > (HALF_W+1)'(MAX_HALF_WIDTH)
             ? (HALF_W+1)'(MAX_HALF_WIDTH) : (HALF_W+1)'(i_half);
        w_ns = (i_nsamp == '0) ? TIME_W'(1) : i_nsamp;
        w_t1 = {1'b0, r_time} + (TIME_W+1)'(1);
        w_last = w_t1 >= {1'b0, w_ns};
        w_dist = (r_i >= r_c) ? (r_i - r_c) : (r_c - r_i);
        w_hi   = {1'b0, r_c} + (TIME_W+1)'(r_h);
        // Ring slots follow the time indices modulo the ring depth; the half
        // window is always shorter than the ring, so one wrap corrects them.
        w_tslot_inc = (r_tslot == SLOT_W'(DEPTH-1)) ? '0 : r_tslot + SLOT_W'(1);
        w_cslot_inc = (r_cslot == SLOT_W'(DEPTH-1)) ? '0 : r_cslot + SLOT_W'(1);
        w_islot_inc = (r_islot == SLOT_W'(DEPTH-1)) ? '0 : r_islot + SLOT_W'(1);
        w_tsub = (r_tslot >= SLOT_W'(w_h)) ? r_tslot - SLOT_W'(w_h)
               : SLOT_W'((SLOT_W+1)'(r_tslot) + (SLOT_W+1)'(DEPTH) - (SLOT_W+1)'(w_h));
        w_csub = (r_cslot >= SLOT_W'(r_h)) ? r_cslot - SLOT_W'(r_h)
               : SLOT_W'((SLOT_W+1)'(r_cslot) + (SLOT_W+1)'(DEPTH) - (SLOT_W+1)'(r_h));
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_take     = i_in_valid && o_in_ready;
    assign o_cnt_next = r_cnt;
    assign o_slot     = r_tslot;
    assign o_rd_slot  = r_islot;
    assign o_weight   = 7'(r_h) + 7'd1 - 7'(w_dist);

    always_comb begin
        o_cmd           = '0;
        o_cmd.col_write = o_take && i_stat.col_done;
        o_cmd.acc_clear = (r_state == S_CLR);
        o_cmd.acc_step  = (r_state == S_WALK);
        o_cmd.mul_d     = (r_state == S_MUL);
        o_cmd.div_init  = (r_state == S_DINI);
        o_cmd.div_step  = (r_state == S_DIV);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_take && i_stat.col_done &&
                        ((r_time >= TIME_W'(w_h)) || w_last)) n_state = S_CLR;
            S_CLR:  n_state = S_WALK;
            S_WALK: if (r_i == r_hi) n_state = S_LAND;
            // The last ring read is added to the sums during this cycle.
            S_LAND: n_state = S_MUL;
            S_MUL:  n_state = S_DINI;
            S_DINI: n_state = S_DIV;
            S_DIV:  if (r_bit == 5'd16) n_state = S_OUT;
            S_OUT: begin
                if (!o_out_valid) begin
                    n_state = (r_c == r_last) ? S_IDLE : S_CLR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_time      <= '0;
            r_tslot     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (o_take) begin
                if (i_stat.col_done) begin
                    r_cnt   <= '0;
                    r_time  <= w_last ? '0 : r_time + TIME_W'(1);
                    r_tslot <= w_last ? '0 : w_tslot_inc;
                end else begin
                    r_cnt <= r_cnt + NREC_W'(1);
                end
            end
            if (r_state == S_OUT && !o_out_valid) o_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_stat.col_done) begin
            r_t <= r_time;
            r_h <= w_h;
            r_c <= (r_time >= TIME_W'(w_h)) ? r_time - TIME_W'(w_h) : '0;
            r_cslot <= (r_time >= TIME_W'(w_h)) ? w_tsub : '0;
            r_last <= w_last ? r_time
                    : ((r_time >= TIME_W'(w_h)) ? r_time - TIME_W'(w_h) : '0);
        end
        case (r_state)
            S_CLR: begin
                r_i     <= (r_c >= TIME_W'(r_h)) ? r_c - TIME_W'(r_h) : '0;
                r_islot <= (r_c >= TIME_W'(r_h)) ? w_csub : '0;
                r_hi    <= (w_hi > {1'b0, r_t}) ? r_t : TIME_W'(w_hi);
            end
            S_WALK: begin
                r_i     <= r_i + TIME_W'(1);
                r_islot <= w_islot_inc;
            end
            S_DINI: r_bit <= '0;
            S_DIV:  r_bit <= r_bit + 5'd1;
            S_OUT: begin
                if (!o_out_valid) begin
                    o_coh   <= i_coh;
                    o_time  <= r_c;
                    o_end   <= (r_c == r_last);
                    r_c     <= r_c + TIME_W'(1);
                    r_cslot <= w_cslot_inc;
                end
            end
            default: ;
        endcase
    end
endmodule

@@ sv/multichannel_semblance.sv @@
// ----------------------------------------------------------------------------
// multichannel_semblance
// Streaming semblance coherency over stacked channels with a triangular
// smoothing window.
// ----------------------------------------------------------------------------
// A sample that does not complete a time index is taken without leaving the
// idle state. A completing sample produces no result until half_window+1
// time indices of the trace have arrived, then one result, and the last time
// index of a trace flushes up to half_window+1 results. Each result takes a
// clear step, a walk over up to 2*half_window+1 ring entries (one per cycle
// on the ring read port), a step for the last read to land, a divisor
// multiply, a divider load, 17 divider steps and a step to load the output
// register, which waits while the previous result is held for i_ready. Input
// is held off until the last result of that sample has been handed to the
// output register.
module multichannel_semblance
    import msemb_pkg::*;
#(
    parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [msemb_pkg::COH_W-1:0]   o_coherence,
    output logic [msemb_pkg::TIME_W-1:0]  o_time_index,
    output logic                          o_run_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
`include "assert_macros.svh"

    logic [NREC_W-1:0] r_nrec;
    logic [TIME_W-1:0] r_nsamp;
    logic [HALF_W-1:0] r_half;
    logic [NREC_W-1:0] w_nrec;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_take;
    logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] w_slot, w_rd_slot;
    logic [6:0] w_weight;
    logic [NREC_W-1:0] w_cnt;
    logic [COH_W-1:0] w_coh;

    assign o_cfg_ready = 1'b1;
    assign w_nrec = (r_nrec == '0) ? NREC_W'(1)
                  : ((int'(r_nrec) > MAX_CHANNELS) ? NREC_W'(MAX_CHANNELS) : r_nrec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrec  <= NREC_W'(1);
            r_nsamp <= TIME_W'(1024);
            r_half  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_RECORDS: r_nrec  <= i_cfg_data[NREC_W-1:0];
                CFG_NUM_SAMPLES: r_nsamp <= i_cfg_data[TIME_W-1:0];
                CFG_HALF_WINDOW: r_half  <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    msemb_ctrl #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_ready(o_ready), .o_take(w_take),
        .i_nrec(w_nrec), .i_nsamp(r_nsamp), .i_half(r_half),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_slot(w_slot), .o_rd_slot(w_rd_slot),
        .o_weight(w_weight), .o_cnt_next(w_cnt), .i_coh(w_coh),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .o_coh(o_coherence), .o_time(o_time_index), .o_end(o_run_end)
    );

    msemb_datapath #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_sample(i_sample),
        .i_nrec(w_nrec), .i_slot(w_slot), .i_rd_slot(w_rd_slot),
        .i_weight(w_weight), .i_cmd(w_cmd), .i_cnt_next(w_cnt),
        .o_stat(w_stat), .o_coh(w_coh)
    );

    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `ASSERT_CLK(a_coh_range, i_clk, i_rst_n, o_valid |-> (o_coherence <= 17'd65536))
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_time_index))
endmodule
